// ===== rtl/core/ffha_pkg.sv =====
// shared types and constants of the first-fit heap allocator
package ffha_pkg;

	// field widths of the request and response words
	localparam int FUNC_W      = 1;
	localparam int REQ_BYTES_W = 21;
	localparam int ADDR_W      = 20;
	localparam int STATUS_W    = 3;
	localparam int MAX_PAGES_W = 9;

	// heap geometry
	localparam int GRAN_SHIFT    = 4;
	localparam int GRAN_BYTES    = 16;
	localparam int PAGE_SHIFT    = 8;
	localparam int PAGE_GRANULES = 256;

	// request size in granules, and the page-rounded growth amount
	localparam int NEED_W = REQ_BYTES_W - GRAN_SHIFT + 1;
	localparam int EXT_W  = NEED_W + 1;

	// configuration register map
	localparam int          PADDR_W         = 3;
	localparam int          PDATA_W         = 32;
	localparam logic        REG_MAX_PAGES   = 1'b0;
	localparam logic [8:0]  MAX_PAGES_RESET = 9'd256;

	// function codes
	localparam logic FUNC_ALLOC = 1'b0;

	// response status codes
	localparam logic [STATUS_W-1:0] ST_ALLOC   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OOM     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

	// walk-and-grow passes per allocate
	localparam logic [1:0] PASS_LAST = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]      func;
		logic [REQ_BYTES_W-1:0] req_bytes;
		logic [ADDR_W-1:0]      free_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   payload_addr;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_GROW0,
		S_WALK_RD,
		S_WALK_CHK,
		S_GROW,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_FREE_NXT,
		S_RESULT
	} state_t;

	typedef enum logic {
		RA_B,
		RA_NXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_GROW0,
		WR_FIT,
		WR_SPLIT,
		WR_GROW,
		WR_FREE_SELF,
		WR_FREE_MERGE
	} wr_sel_t;

	// controller to datapath
	typedef struct packed {
		logic                in_ready;
		logic                load;
		logic                clr_step;
		logic                b_zero;
		logic                b_to_nxt;
		logic                hdr_latch;
		logic                top_set;
		logic                top_add;
		logic                pass_clr;
		logic                pass_inc;
		logic                st_set;
		logic [STATUS_W-1:0] st;
		logic                out_load;
		rd_sel_t             rd_sel;
		wr_sel_t             wr_sel;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_alloc;
		logic zero_req;
		logic top_zero;
		logic grow_ok;
		logic free_bad;
		logic rd_valid;
		logic rd_free;
		logic fits;
		logic split;
		logic has_next;
		logic pass_last;
		logic clear_done;
		logic out_busy;
	} dp_stat_t;

endpackage

// ===== rtl/core/ffha_stream_if.sv =====
// valid/ready channel carrying one word of payload type T
interface ffha_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/ffha_ram.sv =====
// generic single-write, single-read ram with registered read data
module ffha_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/ffha_ctrl.sv =====
// sequencing state machine of the heap allocator
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  ffha_pkg::dp_stat_t stat,
	output ffha_pkg::ctrl_cmd_t cmd
);
	import ffha_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clear_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (stat.is_alloc) begin
					if (stat.zero_req) state_d = S_RESULT;
					else if (stat.top_zero) state_d = stat.grow_ok ? S_GROW0 : S_RESULT;
					else state_d = S_WALK_RD;
				end else begin
					state_d = stat.free_bad ? S_RESULT : S_FREE_RD;
				end
			end
			S_GROW0:   state_d = S_WALK_RD;
			S_WALK_RD: state_d = S_WALK_CHK;
			S_WALK_CHK: begin
				if (!stat.rd_valid) state_d = S_RESULT;
				else if (stat.fits) state_d = stat.split ? S_SPLIT : S_RESULT;
				else if (!stat.has_next) state_d = S_GROW;
			end
			S_GROW: begin
				if (!stat.grow_ok || stat.pass_last) state_d = S_RESULT;
				else state_d = S_WALK_RD;
			end
			S_SPLIT:   state_d = S_RESULT;
			S_FREE_RD: state_d = S_FREE_CHK;
			S_FREE_CHK: begin
				if (!stat.rd_valid || stat.rd_free) state_d = S_RESULT;
				else if (stat.has_next) state_d = S_FREE_NXT;
				else state_d = S_RESULT;
			end
			S_FREE_NXT: state_d = S_RESULT;
			S_RESULT: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.in_ready  = 1'b0;
		cmd.load      = 1'b0;
		cmd.clr_step  = 1'b0;
		cmd.b_zero    = 1'b0;
		cmd.b_to_nxt  = 1'b0;
		cmd.hdr_latch = 1'b0;
		cmd.top_set   = 1'b0;
		cmd.top_add   = 1'b0;
		cmd.pass_clr  = 1'b0;
		cmd.pass_inc  = 1'b0;
		cmd.st_set    = 1'b0;
		cmd.st        = ST_OOM;
		cmd.out_load  = 1'b0;
		cmd.rd_sel    = RA_B;
		cmd.wr_sel    = WR_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_sel   = WR_CLEAR;
				cmd.clr_step = 1'b1;
			end
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = req_valid;
			end
			S_DECODE: begin
				if (stat.is_alloc) begin
					if (stat.zero_req) begin
						cmd.st_set = 1'b1;
						cmd.st     = ST_ZERO;
					end else if (stat.top_zero && !stat.grow_ok) begin
						cmd.st_set = 1'b1;
						cmd.st     = ST_OOM;
					end else begin
						cmd.b_zero   = 1'b1;
						cmd.pass_clr = 1'b1;
					end
				end else if (stat.free_bad) begin
					cmd.st_set = 1'b1;
					cmd.st     = ST_IGNORED;
				end
			end
			S_GROW0: begin
				cmd.wr_sel  = WR_GROW0;
				cmd.top_set = 1'b1;
			end
			S_WALK_RD: begin
				cmd.rd_sel = RA_B;
			end
			S_WALK_CHK: begin
				cmd.hdr_latch = 1'b1;
				if (!stat.rd_valid) begin
					cmd.st_set = 1'b1;
					cmd.st     = ST_OOM;
				end else if (stat.fits) begin
					cmd.wr_sel = WR_FIT;
					cmd.st_set = 1'b1;
					cmd.st     = ST_ALLOC;
				end else if (stat.has_next) begin
					cmd.rd_sel   = RA_NXT;
					cmd.b_to_nxt = 1'b1;
				end
			end
			S_GROW: begin
				if (!stat.grow_ok) begin
					cmd.st_set = 1'b1;
					cmd.st     = ST_OOM;
				end else begin
					cmd.wr_sel   = WR_GROW;
					cmd.top_add  = 1'b1;
					cmd.pass_inc = 1'b1;
					if (stat.pass_last) begin
						cmd.st_set = 1'b1;
						cmd.st     = ST_OOM;
					end else begin
						cmd.b_zero = 1'b1;
					end
				end
			end
			S_SPLIT: begin
				cmd.wr_sel = WR_SPLIT;
			end
			S_FREE_RD: begin
				cmd.rd_sel = RA_B;
			end
			S_FREE_CHK: begin
				cmd.hdr_latch = 1'b1;
				if (!stat.rd_valid || stat.rd_free) begin
					cmd.st_set = 1'b1;
					cmd.st     = ST_IGNORED;
				end else if (stat.has_next) begin
					cmd.rd_sel = RA_NXT;
				end else begin
					cmd.wr_sel = WR_FREE_SELF;
					cmd.st_set = 1'b1;
					cmd.st     = ST_FREED;
				end
			end
			S_FREE_NXT: begin
				cmd.wr_sel = WR_FREE_MERGE;
				cmd.st_set = 1'b1;
				cmd.st     = ST_FREED;
			end
			S_RESULT: begin
				cmd.out_load = !stat.out_busy;
			end
			default: begin
				cmd.in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/ffha_dp.sv =====
// datapath: header ram, heap top, walk pointer, growth math and response register
module ffha_dp #(
	parameter int HEAP_GRANULES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ffha_pkg::ctrl_cmd_t                 cmd,
	output ffha_pkg::dp_stat_t                  stat,
	input  ffha_pkg::req_t                      req_data,
	input  logic [ffha_pkg::MAX_PAGES_W-1:0]    max_pages,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output ffha_pkg::rsp_t                      rsp_data
);
	import ffha_pkg::*;

	localparam int IDX_W = $clog2(HEAP_GRANULES);
	localparam int TOP_W = IDX_W + 1;
	localparam int SZ_W  = IDX_W;
	localparam int HDR_W = SZ_W + 2;
	localparam int SUM_W = ((TOP_W > EXT_W) ? TOP_W : EXT_W) + 1;
	localparam int CMP_W = (SZ_W > NEED_W) ? SZ_W : NEED_W;
	localparam int PW    = ((TOP_W + GRAN_SHIFT) > ADDR_W) ? (TOP_W + GRAN_SHIFT) : ADDR_W;

	// request registers
	logic                  func_q;
	logic                  zero_q;
	logic [NEED_W-1:0]     need_q;
	logic [ADDR_W-1:0]     p_q;
	// walk and heap state
	logic [IDX_W-1:0]      b_q;
	logic                  hfree_q;
	logic [SZ_W-1:0]       size_q;
	logic [TOP_W-1:0]      top_q;
	logic [1:0]            pass_q;
	logic [IDX_W-1:0]      clr_q;
	logic [STATUS_W-1:0]   st_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	// ram ports
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [HDR_W-1:0]      wdata;
	logic [IDX_W-1:0]      raddr;
	logic [HDR_W-1:0]      rdata;

	logic                  rd_valid;
	logic                  rd_free;
	logic [SZ_W-1:0]       rd_size;
	logic [REQ_BYTES_W:0]  bytes_rnd;
	logic [NEED_W-1:0]     need_d;
	logic [EXT_W-1:0]      want_pg;
	logic [EXT_W-1:0]      extra;
	logic [SZ_W-1:0]       extra_sz;
	logic [SUM_W-1:0]      lim_pages;
	logic [SUM_W-1:0]      heap_lim;
	logic [SUM_W-1:0]      grow_sum;
	logic [TOP_W-1:0]      nxt;
	logic [SZ_W-1:0]       left;
	logic [SZ_W-1:0]       need_sz;
	logic [IDX_W:0]        b_inc;

	assign rd_valid = rdata[HDR_W-1];
	assign rd_free  = rdata[HDR_W-2];
	assign rd_size  = rdata[SZ_W-1:0];

	// granules needed, rounded up
	assign bytes_rnd = {1'b0, req_data.req_bytes} + (REQ_BYTES_W+1)'(GRAN_BYTES - 1);
	assign need_d    = NEED_W'(bytes_rnd >> GRAN_SHIFT);

	// growth: need plus header, rounded up to whole pages
	assign want_pg  = EXT_W'(need_q) + EXT_W'(PAGE_GRANULES);
	assign extra    = want_pg & ~EXT_W'(PAGE_GRANULES - 1);
	assign extra_sz = SZ_W'(extra);

	// heap limit and growth check
	assign lim_pages = SUM_W'(max_pages) << PAGE_SHIFT;
	assign heap_lim  = (lim_pages > SUM_W'(HEAP_GRANULES)) ? SUM_W'(HEAP_GRANULES) : lim_pages;
	assign grow_sum  = SUM_W'(top_q) + SUM_W'(extra);

	// next header after the one just read
	assign nxt     = TOP_W'(b_q) + TOP_W'(rd_size) + TOP_W'(1);
	assign need_sz = SZ_W'(need_q);
	assign left    = rd_size - need_sz;
	assign b_inc   = {1'b0, b_q} + (IDX_W+1)'(1);

	// status to controller
	always_comb begin
		stat.is_alloc   = (func_q == FUNC_ALLOC);
		stat.zero_req   = zero_q;
		stat.top_zero   = (top_q == '0);
		stat.grow_ok    = (grow_sum <= heap_lim);
		stat.free_bad   = (p_q == '0) || (top_q == '0) || (p_q[GRAN_SHIFT-1:0] != '0)
			|| (PW'(p_q) >= (PW'(top_q) << GRAN_SHIFT));
		stat.rd_valid   = rd_valid;
		stat.rd_free    = rd_free;
		stat.fits       = rd_free && (CMP_W'(rd_size) >= CMP_W'(need_q));
		stat.split      = (left >= SZ_W'(2));
		stat.has_next   = (nxt < top_q);
		stat.pass_last  = (pass_q == PASS_LAST);
		stat.clear_done = (clr_q == IDX_W'(HEAP_GRANULES - 1));
		stat.out_busy   = rsp_valid_q && !rsp_ready;
	end

	// read address
	assign raddr = (cmd.rd_sel == RA_NXT) ? IDX_W'(nxt) : b_q;

	// write port selection
	always_comb begin
		we    = 1'b1;
		waddr = b_q;
		wdata = '0;
		case (cmd.wr_sel)
			WR_CLEAR: begin
				waddr = clr_q;
			end
			WR_GROW0: begin
				waddr = '0;
				wdata = {2'b11, extra_sz - SZ_W'(1)};
			end
			WR_FIT: begin
				wdata = {2'b10, (left >= SZ_W'(2)) ? need_sz : rd_size};
			end
			WR_SPLIT: begin
				waddr = b_q + IDX_W'(need_q) + IDX_W'(1);
				wdata = {2'b11, size_q - need_sz - SZ_W'(1)};
			end
			WR_GROW: begin
				if (hfree_q) begin
					wdata = {2'b11, size_q + extra_sz};
				end else begin
					waddr = IDX_W'(top_q);
					wdata = {2'b11, extra_sz - SZ_W'(1)};
				end
			end
			WR_FREE_SELF: begin
				wdata = {2'b11, rd_size};
			end
			WR_FREE_MERGE: begin
				wdata = {2'b11, (rd_valid && rd_free) ? (size_q + rd_size + SZ_W'(1)) : size_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	ffha_ram #(
		.WIDTH(HDR_W),
		.DEPTH(HEAP_GRANULES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			pass_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + IDX_W'(1);
			if (cmd.top_set) top_q <= TOP_W'(extra);
			else if (cmd.top_add) top_q <= top_q + TOP_W'(extra);
			if (cmd.pass_clr) pass_q <= '0;
			else if (cmd.pass_inc) pass_q <= pass_q + 2'd1;
			if (cmd.out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= req_data.func;
			zero_q <= (req_data.req_bytes == '0);
			need_q <= need_d;
			p_q    <= req_data.free_addr;
			b_q    <= IDX_W'(req_data.free_addr >> GRAN_SHIFT) - IDX_W'(1);
		end else if (cmd.b_zero) begin
			b_q <= '0;
		end else if (cmd.b_to_nxt) begin
			b_q <= IDX_W'(nxt);
		end
		if (cmd.hdr_latch) begin
			hfree_q <= rd_free;
			size_q  <= rd_size;
		end
		if (cmd.st_set) st_q <= cmd.st;
		if (cmd.out_load) begin
			rsp_q.status       <= st_q;
			rsp_q.payload_addr <= (st_q == ST_ALLOC) ? ADDR_W'({b_inc, 4'b0000}) : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

// ===== rtl/core/first_fit_heap_allocator_core.sv =====
// top level of the first-fit heap allocator: config register and block wiring
//
//  channel | dir | handshake          | word
//  req     | in  | valid/ready        | func, req_bytes, free_addr
//  rsp     | out | valid/ready        | payload_addr, status
//  apb     | in  | psel/penable/pwrite| max_pages at byte address 0
//
// allocate walks the headers and grows the heap when a walk pass finds no fit,
// at most three passes; an empty heap is grown first, and a fitting block is
// split when enough is left. a zero size or empty-heap refusal and a bad free
// address go straight to the result; any other free reads its header and may
// merge the next free block. one word is in flight at a time. after reset a clearing
// pass writes every header entry, with req.ready low. a stalled rsp holds the
// response register; req is taken again once the response has moved into it.
module first_fit_heap_allocator_core #(
	parameter int HEAP_GRANULES = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ffha_stream_if.sink                     req,
	ffha_stream_if.source                   rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ffha_pkg::PADDR_W-1:0]    paddr,
	input  logic [ffha_pkg::PDATA_W-1:0]    pwdata,
	output logic [ffha_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import ffha_pkg::*;

	logic [MAX_PAGES_W-1:0] max_pages_q;
	ctrl_cmd_t              cmd;
	dp_stat_t               stat;
	logic                   reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_MAX_PAGES);

	// max_pages register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pages_q <= MAX_PAGES_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			max_pages_q <= pwdata[MAX_PAGES_W-1:0];
		end
	end

	// register read back
	assign prdata = reg_hit ? PDATA_W'(max_pages_q) : '0;

	assign req.ready = cmd.in_ready;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffha_dp #(
		.HEAP_GRANULES(HEAP_GRANULES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.req_data (req.data),
		.max_pages(max_pages_q),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.rsp_data (rsp.data)
	);

endmodule
